// ----- rtl/dpfe_pkg.sv -----
// Package of the drift pulse feature extractor: field widths, register codes, reset values,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package dpfe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 17;
    localparam int THR_W      = 13;
    localparam int DIV_W      = 7;
    localparam int BACKOFF_W  = 6;
    localparam int WLEN_W     = 10;
    localparam int OFS_W      = 7;
    localparam int START_W    = 10;
    localparam int END_W      = 11;
    localparam int WSUM_W     = 27;
    localparam int SLOPE_W    = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USED_W = 2 + SUM_W + START_W + END_W + WSUM_W + SLOPE_W;

    // The threshold magnitude is 13 bits, so the divider retires one quotient bit a step.
    localparam int DIV_STEPS  = THR_W;
    localparam int DIV_CNT_W  = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EVENT_THRESHOLD = 3'd0,
        CFG_END_DIVISOR     = 3'd1,
        CFG_SAFE_LOW        = 3'd2,
        CFG_SAFE_HIGH       = 3'd3,
        CFG_START_BACKOFF   = 3'd4,
        CFG_WINDOW_LENGTH   = 3'd5,
        CFG_LEFT_OFFSET     = 3'd6,
        CFG_RIGHT_OFFSET    = 3'd7
    } t_cfg_addr;

    localparam logic signed [THR_W-1:0]    RST_EVENT_THRESHOLD = -13'sd80;
    localparam logic [DIV_W-1:0]           RST_END_DIVISOR     = 7'd8;
    localparam logic signed [SAMPLE_W-1:0] RST_SAFE_LOW        = -16'sd2000;
    localparam logic signed [SAMPLE_W-1:0] RST_SAFE_HIGH       = 16'sd25;
    localparam logic [BACKOFF_W-1:0]       RST_START_BACKOFF   = 6'd2;
    localparam logic [WLEN_W-1:0]          RST_WINDOW_LENGTH   = 10'd25;
    localparam logic signed [OFS_W-1:0]    RST_LEFT_OFFSET     = 7'sd0;
    localparam logic signed [OFS_W-1:0]    RST_RIGHT_OFFSET    = 7'sd0;

    typedef struct packed {
        logic signed [THR_W-1:0]    event_threshold;
        logic [DIV_W-1:0]           end_divisor;
        logic signed [SAMPLE_W-1:0] safe_low;
        logic signed [SAMPLE_W-1:0] safe_high;
        logic [BACKOFF_W-1:0]       start_backoff;
        logic [WLEN_W-1:0]          window_length;
        logic signed [OFS_W-1:0]    left_offset;
        logic signed [OFS_W-1:0]    right_offset;
    } t_cfg;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_DIV,
        S_SCAN,
        S_SUM_INIT,
        S_SUM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic scan_init;
        logic scan;
        logic sum_init;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic sum_needed;
        logic sum_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/dpfe_div.sv -----
// Restoring divider that works out the pulse-over level magnitude, one quotient bit a cycle.
// Depends on dpfe_pkg.
`default_nettype none

module dpfe_div import dpfe_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [THR_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [THR_W-1:0]      o_quotient
);

    logic [DIV_W-1:0]     r_rem;
    logic [THR_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W:0] partial;
    logic [DIV_W:0] diff;
    logic           fits;

    assign partial = {r_rem, r_quo[THR_W-1]};
    assign diff    = partial - {1'b0, r_div};
    assign fits    = partial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
            r_quo <= {r_quo[THR_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/dpfe_dp.sv -----
// Datapath of the drift pulse feature extractor: sample store, per-sample checks, the scan
// and window walks, the divider and the output register. Depends on dpfe_pkg and dpfe_div.
`default_nettype none

module dpfe_dp import dpfe_pkg::*; #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire t_cfg                       i_cfg,
    input  wire logic signed [SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_right_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [OUT_DATA_W-1:0]           o_out_data
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int EW   = ((AW > WLEN_W) ? AW : WLEN_W) + 1;
    localparam int ACCW = SUM_W + AW;
    localparam int SATW = (ACCW > WSUM_W) ? ACCW : WSUM_W;

    localparam logic [CW-1:0]             DEPTH    = CW'(MAX_SAMPLES);
    localparam logic signed [SUM_W:0]     PAIR_MAX = (SUM_W+1)'((2**(SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0]     PAIR_MIN = (SUM_W+1)'(-(2**(SUM_W-1)));
    localparam logic signed [SATW-1:0]    WSUM_MAX = SATW'((2**(WSUM_W-1)) - 1);
    localparam logic signed [SATW-1:0]    WSUM_MIN = SATW'(-(2**(WSUM_W-1)));

    // Sample store and its registered read port.
    logic signed [SUM_W-1:0] r_store [MAX_SAMPLES];
    logic signed [SUM_W-1:0] r_rdata;
    logic [CW-1:0]           r_rd_idx;
    logic                    r_rd_scan;
    logic                    r_rd_sum;

    // Wave state.
    logic [CW-1:0]           r_count;
    logic signed [SUM_W-1:0] r_min;
    logic                    r_fault;
    logic                    r_cross;
    logic                    r_ended;
    logic [CW-1:0]           r_ptr;
    logic [EW-1:0]           r_start;
    logic [EW-1:0]           r_end;
    logic signed [ACCW-1:0]  r_acc;
    logic signed [SUM_W-1:0] r_first;
    logic signed [SUM_W-1:0] r_last;

    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    // Per-sample offset removal, range check and saturating pair sum.
    logic signed [SUM_W-1:0] left_adj;
    logic signed [SUM_W-1:0] right_adj;
    logic signed [SUM_W-1:0] safe_lo;
    logic signed [SUM_W-1:0] safe_hi;
    logic signed [SUM_W:0]   pair_sum;
    logic signed [SUM_W-1:0] pair_sat;
    logic                    range_bad;
    logic                    store_open;
    logic                    write_en;

    assign left_adj  = SUM_W'(i_left_sample) - SUM_W'(i_cfg.left_offset);
    assign right_adj = SUM_W'(i_right_sample) - SUM_W'(i_cfg.right_offset);
    assign safe_lo   = SUM_W'(i_cfg.safe_low);
    assign safe_hi   = SUM_W'(i_cfg.safe_high);
    assign pair_sum  = (SUM_W+1)'(left_adj) + (SUM_W+1)'(right_adj);
    assign range_bad = (left_adj < safe_lo) || (right_adj < safe_lo) ||
                       (left_adj > safe_hi) || (right_adj > safe_hi);

    always_comb begin
        if (pair_sum > PAIR_MAX) begin
            pair_sat = PAIR_MAX[SUM_W-1:0];
        end else if (pair_sum < PAIR_MIN) begin
            pair_sat = PAIR_MIN[SUM_W-1:0];
        end else begin
            pair_sat = pair_sum[SUM_W-1:0];
        end
    end

    assign store_open = i_cmd.load && (r_count < DEPTH);
    assign write_en   = store_open && !r_fault && !range_bad;

    // Pulse-over level: threshold divided by the divisor, truncating toward zero.
    logic                    thr_neg;
    logic [THR_W-1:0]        thr_mag;
    logic [DIV_W-1:0]        divisor;
    logic [THR_W-1:0]        quotient;
    logic                    div_done;
    logic signed [THR_W:0]   over_level;

    assign thr_neg = i_cfg.event_threshold[THR_W-1];
    assign thr_mag = thr_neg ? THR_W'(-i_cfg.event_threshold) : i_cfg.event_threshold;
    assign divisor = (i_cfg.end_divisor == '0) ? DIV_W'(1) : i_cfg.end_divisor;

    dpfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (thr_mag),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign over_level = thr_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

    // Read issue for both walks.
    logic issue_scan;
    logic issue_sum;

    assign issue_scan = i_cmd.scan && (r_ptr < r_count);
    assign issue_sum  = i_cmd.sum && (EW'(r_ptr) <= r_end);

    // Scan evaluation on the data that came back from the store.
    logic [EW-1:0] rd_idx_ext;
    logic [EW-1:0] backoff_ext;
    logic [EW-1:0] cand_start;
    logic [EW-1:0] start_now;
    logic          cross_now;
    logic          end_hit;

    assign rd_idx_ext  = EW'(r_rd_idx);
    assign backoff_ext = EW'(i_cfg.start_backoff);
    assign cand_start  = (rd_idx_ext < backoff_ext) ? '0 : rd_idx_ext - backoff_ext;
    assign cross_now   = r_rd_scan && !r_cross &&
                         (r_rdata < SUM_W'(i_cfg.event_threshold));
    assign start_now   = cross_now ? cand_start : r_start;
    assign end_hit     = r_rd_scan && (r_cross || cross_now) && (start_now != '0) &&
                         (r_rdata > SUM_W'(over_level)) && !r_ended;

    // Result assembly.
    logic                     good;
    logic                     ended_out;
    logic signed [SATW-1:0]   acc_ext;
    logic signed [WSUM_W-1:0] wsum_sat;
    logic [OUT_USED_W-1:0]    result;

    assign good      = !r_fault && r_cross;
    assign ended_out = good && r_ended;
    assign acc_ext   = SATW'(r_acc);

    always_comb begin
        if (acc_ext > WSUM_MAX) begin
            wsum_sat = WSUM_MAX[WSUM_W-1:0];
        end else if (acc_ext < WSUM_MIN) begin
            wsum_sat = WSUM_MIN[WSUM_W-1:0];
        end else begin
            wsum_sat = acc_ext[WSUM_W-1:0];
        end
    end

    assign result = {
        ended_out ? (SLOPE_W'(r_first) - SLOPE_W'(r_last)) : SLOPE_W'(0),
        ended_out ? wsum_sat : WSUM_W'(0),
        good ? r_end[END_W-1:0] : END_W'(0),
        good ? r_start[START_W-1:0] : START_W'(0),
        good ? r_min : SUM_W'(0),
        ended_out,
        good
    };

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_store[r_count[AW-1:0]] <= pair_sat;
        end
        r_rdata  <= r_store[r_ptr[AW-1:0]];
        r_rd_idx <= r_ptr;
    end

    // Control and wave state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min       <= '0;
            r_fault     <= 1'b0;
            r_cross     <= 1'b0;
            r_ended     <= 1'b0;
            r_ptr       <= '0;
            r_rd_scan   <= 1'b0;
            r_rd_sum    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_scan <= issue_scan;
            r_rd_sum  <= issue_sum;

            if (store_open) begin
                r_count <= r_count + CW'(1);
                if (!r_fault && range_bad) begin
                    r_fault <= 1'b1;
                end
                if (write_en && (pair_sat < r_min)) begin
                    r_min <= pair_sat;
                end
            end

            if (i_cmd.scan_init) begin
                r_ptr <= '0;
            end else if (i_cmd.sum_init) begin
                r_ptr <= r_start[CW-1:0];
            end else if (issue_scan || issue_sum) begin
                r_ptr <= r_ptr + CW'(1);
            end

            if (cross_now) begin
                r_cross <= 1'b1;
            end
            if (end_hit) begin
                r_ended <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // The wave state returns to its reset value once the result is latched.
            if (i_cmd.emit) begin
                r_count <= '0;
                r_min   <= '0;
                r_fault <= 1'b0;
                r_cross <= 1'b0;
                r_ended <= 1'b0;
            end
        end
    end

    // Window bounds, sums and the output payload.
    always_ff @(posedge i_clk) begin
        if (cross_now) begin
            r_start <= cand_start;
        end
        // A sample that both crosses and ends the pulse sets the end to its own index.
        if (end_hit) begin
            r_end <= rd_idx_ext;
        end else if (cross_now) begin
            r_end <= cand_start + EW'(i_cfg.window_length);
        end

        if (i_cmd.sum_init) begin
            r_acc <= '0;
        end else if (r_rd_sum) begin
            if (rd_idx_ext < r_end) begin
                r_acc <= r_acc + ACCW'(r_rdata);
            end
        end
        if (r_rd_sum && (rd_idx_ext == r_start)) begin
            r_first <= r_rdata;
        end
        if (r_rd_sum && (rd_idx_ext == r_end)) begin
            r_last <= r_rdata;
        end

        if (i_cmd.emit) begin
            r_out_data <= OUT_DATA_W'(result);
        end
    end

    assign o_status.div_done   = div_done;
    assign o_status.scan_done  = !(r_ptr < r_count) && !r_rd_scan;
    assign o_status.sum_needed = ended_out;
    assign o_status.sum_done   = (EW'(r_ptr) > r_end) && !r_rd_sum;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/dpfe_ctrl.sv -----
// Controller of the drift pulse feature extractor: sequences loading, division, the scan
// walk, the window walk and the hand-off to the output register. Depends on dpfe_pkg.
`default_nettype none

module dpfe_ctrl import dpfe_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_last,
    output logic         o_in_ready,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = i_status.sum_needed ? S_SUM_INIT : S_EMIT;
                end
            end
            S_SUM_INIT: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (i_status.sum_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.scan_init = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_SUM_INIT: begin
                o_cmd.sum_init = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/drift_pulse_feature_extract.sv -----
// Drift pulse feature extractor, top level: configuration registers, controller and datapath.
// Depends on dpfe_pkg, dpfe_ctrl and dpfe_dp.
//
// One waveform arrives as a run of left/right sample transfers, the final one marked by
// tlast; the samples are loaded as they arrive. After the final sample the block works on
// the wave in steps: a set-up step, the divider that works out the pulse-over level (13
// quotient bits and a done flag), a walk over all stored samples through the single
// registered read port of the store to find the window, when the pulse ended a second
// walk over the window for the sums, and the hand-off of the record to the output
// register, which waits while that register still holds an untaken record.
// No further sample is taken during that time.
// The store needs no clearing pass after reset. The finished result waits in the output
// register, so the next waveform can load while it is still to be taken.
`default_nettype none

module drift_pulse_feature_extract import dpfe_pkg::*; #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] wave_good, [1] pulse_ended, [18:2] minimum_sum, [28:19] start_index,
    // [39:29] end_index, [66:40] window_sum, [84:67] slope_sum, [87:85] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.event_threshold <= RST_EVENT_THRESHOLD;
            r_cfg.end_divisor     <= RST_END_DIVISOR;
            r_cfg.safe_low        <= RST_SAFE_LOW;
            r_cfg.safe_high       <= RST_SAFE_HIGH;
            r_cfg.start_backoff   <= RST_START_BACKOFF;
            r_cfg.window_length   <= RST_WINDOW_LENGTH;
            r_cfg.left_offset     <= RST_LEFT_OFFSET;
            r_cfg.right_offset    <= RST_RIGHT_OFFSET;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_EVENT_THRESHOLD: r_cfg.event_threshold <= i_cfg_data[THR_W-1:0];
                CFG_END_DIVISOR:     r_cfg.end_divisor     <= i_cfg_data[DIV_W-1:0];
                CFG_SAFE_LOW:        r_cfg.safe_low        <= i_cfg_data;
                CFG_SAFE_HIGH:       r_cfg.safe_high       <= i_cfg_data;
                CFG_START_BACKOFF:   r_cfg.start_backoff   <= i_cfg_data[BACKOFF_W-1:0];
                CFG_WINDOW_LENGTH:   r_cfg.window_length   <= i_cfg_data[WLEN_W-1:0];
                CFG_LEFT_OFFSET:     r_cfg.left_offset     <= i_cfg_data[OFS_W-1:0];
                CFG_RIGHT_OFFSET:    r_cfg.right_offset    <= i_cfg_data[OFS_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    dpfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    dpfe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg          (r_cfg),
        .i_left_sample  ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .i_right_sample ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire
